@@ src/sfsu_pkg.sv @@
`timescale 1ns / 1ps
package sfsu_pkg;

    localparam int MAX_DEPTH       = 500;
    localparam int DEPTH_STEP      = 8;
    localparam int ROT_STAGES      = 8;
    localparam int STEPS_PER_STAGE = 2;
    localparam int DIV_BITS        = 16;
    localparam int DIV_STAGES      = DIV_BITS + 1;

    typedef enum logic [2:0] {
        REG_SCREEN_WIDTH  = 3'd0,
        REG_SCREEN_HEIGHT = 3'd1,
        REG_HOLE1_X       = 3'd2,
        REG_HOLE1_Y       = 3'd3,
        REG_HOLE2_X       = 3'd4,
        REG_HOLE2_Y       = 3'd5,
        REG_ROTATE_SHIFT  = 3'd6,
        REG_ROTATE_STEPS  = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [8:0]         z;
    } star_t;

    typedef struct packed {
        logic [9:0]  rem;
        logic [15:0] dq;
        logic        neg;
    } div_lane_t;

endpackage

@@ src/sfsu_rot.sv @@
`timescale 1ns / 1ps
module sfsu_rot
    import sfsu_pkg::*;
(
    input  logic                clk,
    input  logic                en,
    input  star_t               star_in,
    input  logic signed [15:0]  rand_x,
    input  logic signed [15:0]  rand_y,
    input  logic [3:0]          rotate_shift,
    input  logic [4:0]          rotate_steps,
    output star_t               star_out
);

    // Each stage performs up to two shift-add rotation steps; a respawned star skips them.
    star_t st_reg  [ROT_STAGES];
    star_t st_next [ROT_STAGES];
    logic  rsp_reg  [ROT_STAGES];
    logic  rsp_next [ROT_STAGES];

    function automatic star_t rot_step(star_t s, logic [3:0] sh, logic cw);
        star_t r;
        begin
            r = s;
            if (cw)
            begin
                r.x = s.x + (s.y >>> sh);
                r.y = s.y - (r.x >>> sh);
            end
            else
            begin
                r.x = s.x - (s.y >>> sh);
                r.y = s.y + (r.x >>> sh);
            end
            return r;
        end
    endfunction

    always_comb
    begin
        star_t      cur;
        logic       flag;
        logic [4:0] mag;
        mag = rotate_steps[4] ? 5'(-rotate_steps) : rotate_steps;
        for (int i = 0; i < ROT_STAGES; i++)
        begin
            if (i == 0)
            begin
                if (star_in.z <= 9'(DEPTH_STEP))
                begin
                    cur.x = rand_x;
                    cur.y = rand_y;
                    cur.z = 9'(MAX_DEPTH);
                    flag  = 1'b1;
                end
                else
                begin
                    cur   = star_in;
                    cur.z = star_in.z - 9'(DEPTH_STEP);
                    flag  = 1'b0;
                end
            end
            else
            begin
                cur  = st_reg[i-1];
                flag = rsp_reg[i-1];
            end
            for (int j = 0; j < STEPS_PER_STAGE; j++)
            begin
                if (!flag && (5'(i * STEPS_PER_STAGE + j) < mag))
                begin
                    cur = rot_step(cur, rotate_shift, rotate_steps[4]);
                end
            end
            st_next[i]  = cur;
            rsp_next[i] = flag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < ROT_STAGES; i++)
            begin
                st_reg[i]  <= st_next[i];
                rsp_reg[i] <= rsp_next[i];
            end
        end
    end

    assign star_out = st_reg[ROT_STAGES-1];

endmodule

@@ src/sfsu_div.sv @@
`timescale 1ns / 1ps
module sfsu_div
    import sfsu_pkg::*;
(
    input  logic                clk,
    input  logic                en,
    input  logic signed [15:0]  num_x,
    input  logic signed [15:0]  num_y,
    input  logic [8:0]          den,
    output logic signed [16:0]  quo_x,
    output logic signed [16:0]  quo_y
);

    // Restoring division on magnitudes, one quotient bit per stage, truncating toward zero.
    div_lane_t lx_reg  [DIV_BITS];
    div_lane_t ly_reg  [DIV_BITS];
    div_lane_t lx_next [DIV_BITS];
    div_lane_t ly_next [DIV_BITS];
    logic [8:0] den_reg [DIV_BITS];
    logic signed [16:0] quo_x_reg;
    logic signed [16:0] quo_y_reg;

    function automatic div_lane_t div_step(div_lane_t a, logic [8:0] d);
        div_lane_t  r;
        logic [9:0] trial;
        begin
            trial = {a.rem[8:0], a.dq[15]};
            r.neg = a.neg;
            if (trial >= {1'b0, d})
            begin
                r.rem = trial - {1'b0, d};
                r.dq  = {a.dq[14:0], 1'b1};
            end
            else
            begin
                r.rem = trial;
                r.dq  = {a.dq[14:0], 1'b0};
            end
            return r;
        end
    endfunction

    function automatic div_lane_t div_load(logic signed [15:0] v);
        div_lane_t r;
        begin
            r.rem = '0;
            r.neg = v[15];
            r.dq  = v[15] ? 16'(-v) : v;
            return r;
        end
    endfunction

    always_comb
    begin
        for (int i = 0; i < DIV_BITS; i++)
        begin
            if (i == 0)
            begin
                lx_next[i] = div_step(div_load(num_x), den);
                ly_next[i] = div_step(div_load(num_y), den);
            end
            else
            begin
                lx_next[i] = div_step(lx_reg[i-1], den_reg[i-1]);
                ly_next[i] = div_step(ly_reg[i-1], den_reg[i-1]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < DIV_BITS; i++)
            begin
                lx_reg[i]  <= lx_next[i];
                ly_reg[i]  <= ly_next[i];
                den_reg[i] <= (i == 0) ? den : den_reg[i-1];
            end
            quo_x_reg <= lx_reg[DIV_BITS-1].neg ? -$signed({1'b0, lx_reg[DIV_BITS-1].dq})
                                                 :  $signed({1'b0, lx_reg[DIV_BITS-1].dq});
            quo_y_reg <= ly_reg[DIV_BITS-1].neg ? -$signed({1'b0, ly_reg[DIV_BITS-1].dq})
                                                 :  $signed({1'b0, ly_reg[DIV_BITS-1].dq});
        end
    end

    assign quo_x = quo_x_reg;
    assign quo_y = quo_y_reg;

endmodule

@@ src/starfield_star_update.sv @@
`timescale 1ns / 1ps
// Path from an accepted input transaction to its result at the output register: 8 rotation
// stages, 17 divider stages, one output stage. Throughput: one star per cycle unless the
// output stalls; the two dividers per position are fully pipelined.
// Reset: rst_n clears all valid bits and loads the configuration registers with their defaults.
module starfield_star_update
    import sfsu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] star_x,
    input  logic signed [15:0] star_y,
    input  logic [8:0]         star_z,
    input  logic [4:0]         star_color,
    input  logic signed [15:0] rand_xa,
    input  logic signed [15:0] rand_ya,
    input  logic signed [15:0] rand_xb,
    input  logic signed [15:0] rand_yb,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               erase_valid,
    output logic [11:0]        erase_px,
    output logic [11:0]        erase_py,
    output logic               draw_valid,
    output logic [11:0]        draw_px,
    output logic [11:0]        draw_py,
    output logic [4:0]         draw_color,
    output logic signed [15:0] next_x,
    output logic signed [15:0] next_y,
    output logic [8:0]         next_z
);

    localparam int VLD_STAGES = ROT_STAGES + DIV_STAGES;

    // Sideband carried beside the rotation stages.
    typedef struct packed {
        star_t              old;
        logic [4:0]         color;
        logic signed [15:0] rxb;
        logic signed [15:0] ryb;
    } side_a_t;

    // Sideband carried beside the divider stages.
    typedef struct packed {
        star_t              nxt;
        logic [4:0]         color;
        logic signed [15:0] rxb;
        logic signed [15:0] ryb;
        logic               old_zero;
    } side_b_t;

    // Configuration registers.
    logic [12:0] width_reg;
    logic [12:0] height_reg;
    logic [31:0] hole1_x_reg;
    logic [31:0] hole1_y_reg;
    logic [31:0] hole2_x_reg;
    logic [31:0] hole2_y_reg;
    logic [3:0]  shift_reg;
    logic [4:0]  steps_reg;

    reg_idx_t cfg_idx;
    logic     cfg_wr;

    assign cfg_idx = reg_idx_t'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= 13'd1024;
            height_reg  <= 13'd768;
            hole1_x_reg <= '0;
            hole1_y_reg <= '0;
            hole2_x_reg <= '0;
            hole2_y_reg <= '0;
            shift_reg   <= 4'd6;
            steps_reg   <= 5'd3;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_SCREEN_WIDTH:  width_reg   <= pwdata[12:0];
                REG_SCREEN_HEIGHT: height_reg  <= pwdata[12:0];
                REG_HOLE1_X:       hole1_x_reg <= pwdata;
                REG_HOLE1_Y:       hole1_y_reg <= pwdata;
                REG_HOLE2_X:       hole2_x_reg <= pwdata;
                REG_HOLE2_Y:       hole2_y_reg <= pwdata;
                REG_ROTATE_SHIFT:  shift_reg   <= pwdata[3:0];
                REG_ROTATE_STEPS:  steps_reg   <= pwdata[4:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_SCREEN_WIDTH:  prdata = {19'd0, width_reg};
            REG_SCREEN_HEIGHT: prdata = {19'd0, height_reg};
            REG_HOLE1_X:       prdata = hole1_x_reg;
            REG_HOLE1_Y:       prdata = hole1_y_reg;
            REG_HOLE2_X:       prdata = hole2_x_reg;
            REG_HOLE2_Y:       prdata = hole2_y_reg;
            REG_ROTATE_SHIFT:  prdata = {28'd0, shift_reg};
            REG_ROTATE_STEPS:  prdata = {27'd0, steps_reg};
            default:           prdata = '0;
        endcase
    end

    // The whole pipeline advances together whenever the output register is free or drained.
    // A stalled output freezes every stage, so no transaction is lost or repeated.
    logic adv;
    logic out_valid_reg;
    logic vld_reg [VLD_STAGES];

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < VLD_STAGES; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            for (int i = 0; i < VLD_STAGES; i++)
            begin
                vld_reg[i] <= (i == 0) ? in_valid : vld_reg[i-1];
            end
            out_valid_reg <= vld_reg[VLD_STAGES-1];
        end
    end

    // Rotation and depth update.
    star_t star_in_s;
    star_t star_rot;

    assign star_in_s.x = star_x;
    assign star_in_s.y = star_y;
    assign star_in_s.z = star_z;

    sfsu_rot u_rot (
        .clk          (clk),
        .en           (adv),
        .star_in      (star_in_s),
        .rand_x       (rand_xa),
        .rand_y       (rand_ya),
        .rotate_shift (shift_reg),
        .rotate_steps (steps_reg),
        .star_out     (star_rot)
    );

    side_a_t sa_reg [ROT_STAGES];
    side_b_t sb_reg [DIV_STAGES];
    side_a_t sa_in;
    side_b_t sb_in;

    assign sa_in.old   = star_in_s;
    assign sa_in.color = star_color;
    assign sa_in.rxb   = rand_xb;
    assign sa_in.ryb   = rand_yb;

    assign sb_in.nxt      = star_rot;
    assign sb_in.color    = sa_reg[ROT_STAGES-1].color;
    assign sb_in.rxb      = sa_reg[ROT_STAGES-1].rxb;
    assign sb_in.ryb      = sa_reg[ROT_STAGES-1].ryb;
    assign sb_in.old_zero = (sa_reg[ROT_STAGES-1].old.z == 9'd0);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < ROT_STAGES; i++)
            begin
                sa_reg[i] <= (i == 0) ? sa_in : sa_reg[i-1];
            end
            for (int i = 0; i < DIV_STAGES; i++)
            begin
                sb_reg[i] <= (i == 0) ? sb_in : sb_reg[i-1];
            end
        end
    end

    // Projection dividers: one pair for the old position, one for the new.
    logic signed [16:0] oqx, oqy, nqx, nqy;

    sfsu_div u_div_old (
        .clk   (clk),
        .en    (adv),
        .num_x (sa_reg[ROT_STAGES-1].old.x),
        .num_y (sa_reg[ROT_STAGES-1].old.y),
        .den   (sa_reg[ROT_STAGES-1].old.z),
        .quo_x (oqx),
        .quo_y (oqy)
    );

    sfsu_div u_div_new (
        .clk   (clk),
        .en    (adv),
        .num_x (star_rot.x),
        .num_y (star_rot.y),
        .den   (star_rot.z),
        .quo_x (nqx),
        .quo_y (nqy)
    );

    // Screen and hole tests are done at full precision on 19-bit signed pixel positions.
    function automatic logic in_hole(logic signed [18:0] px, logic signed [18:0] py,
                                     logic [31:0] hx, logic [31:0] hy);
        logic signed [18:0] x1, x2, y1, y2;
        begin
            x1 = 19'($signed(hx[15:0]));
            x2 = 19'($signed(hx[31:16]));
            y1 = 19'($signed(hy[15:0]));
            y2 = 19'($signed(hy[31:16]));
            return (px >= x1) && (px < x2) && (py >= y1) && (py < y2);
        end
    endfunction

    side_b_t            sb_last;
    logic signed [18:0] opx, opy, npx, npy;
    logic signed [18:0] w_s, h_s;
    logic               old_on, new_on, old_hole, new_hole, ev, dv;

    assign sb_last = sb_reg[DIV_STAGES-1];
    assign w_s     = $signed({6'd0, width_reg});
    assign h_s     = $signed({6'd0, height_reg});
    assign opx     = 19'(oqx) + $signed({7'd0, width_reg[12:1]});
    assign opy     = 19'(oqy) + $signed({7'd0, height_reg[12:1]});
    assign npx     = 19'(nqx) + $signed({7'd0, width_reg[12:1]});
    assign npy     = 19'(nqy) + $signed({7'd0, height_reg[12:1]});

    assign old_on   = !opx[18] && (opx < w_s) && !opy[18] && (opy < h_s);
    assign new_on   = !npx[18] && (npx < w_s) && !npy[18] && (npy < h_s);
    assign old_hole = in_hole(opx, opy, hole1_x_reg, hole1_y_reg)
                   || in_hole(opx, opy, hole2_x_reg, hole2_y_reg);
    assign new_hole = in_hole(npx, npy, hole1_x_reg, hole1_y_reg)
                   || in_hole(npx, npy, hole2_x_reg, hole2_y_reg);
    assign ev       = !sb_last.old_zero && old_on && !old_hole;
    assign dv       = new_on && !new_hole;

    logic               erase_valid_reg, draw_valid_reg;
    logic [11:0]        erase_px_reg, erase_py_reg, draw_px_reg, draw_py_reg;
    logic [4:0]         draw_color_reg;
    logic signed [15:0] next_x_reg, next_y_reg;
    logic [8:0]         next_z_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            erase_valid_reg <= ev;
            erase_px_reg    <= ev ? opx[11:0] : 12'd0;
            erase_py_reg    <= ev ? opy[11:0] : 12'd0;
            draw_valid_reg  <= dv;
            draw_px_reg     <= dv ? npx[11:0] : 12'd0;
            draw_py_reg     <= dv ? npy[11:0] : 12'd0;
            draw_color_reg  <= dv ? sb_last.color : 5'd0;
            if (new_on)
            begin
                next_x_reg <= sb_last.nxt.x;
                next_y_reg <= sb_last.nxt.y;
                next_z_reg <= sb_last.nxt.z;
            end
            else
            begin
                // The star left the screen and respawns at the far plane.
                next_x_reg <= sb_last.rxb;
                next_y_reg <= sb_last.ryb;
                next_z_reg <= 9'(MAX_DEPTH);
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign erase_valid = erase_valid_reg;
    assign erase_px    = erase_px_reg;
    assign erase_py    = erase_py_reg;
    assign draw_valid  = draw_valid_reg;
    assign draw_px     = draw_px_reg;
    assign draw_py     = draw_py_reg;
    assign draw_color  = draw_color_reg;
    assign next_x      = next_x_reg;
    assign next_y      = next_y_reg;
    assign next_z      = next_z_reg;

endmodule

@@ test/tb_starfield_star_update.sv @@
`timescale 1ns / 1ps
module tb_starfield_star_update;
    import sfsu_pkg::*;

    // Pipeline depth of the block, from an accepted input transaction to its answer.
    localparam int PIPE_LATENCY = 26;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int PRINT_LIMIT  = 60;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [4:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid;
    logic               in_ready;
    logic signed [15:0] star_x;
    logic signed [15:0] star_y;
    logic [8:0]         star_z;
    logic [4:0]         star_color;
    logic signed [15:0] rand_xa;
    logic signed [15:0] rand_ya;
    logic signed [15:0] rand_xb;
    logic signed [15:0] rand_yb;
    logic               out_valid;
    logic               out_ready;
    logic               erase_valid;
    logic [11:0]        erase_px;
    logic [11:0]        erase_py;
    logic               draw_valid;
    logic [11:0]        draw_px;
    logic [11:0]        draw_py;
    logic [4:0]         draw_color;
    logic signed [15:0] next_x;
    logic signed [15:0] next_y;
    logic [8:0]         next_z;

    // One expected output transaction of the block.
    typedef struct {
        logic        erase_valid;
        logic [11:0] erase_px;
        logic [11:0] erase_py;
        logic        draw_valid;
        logic [11:0] draw_px;
        logic [11:0] draw_py;
        logic [4:0]  draw_color;
        logic [15:0] next_x;
        logic [15:0] next_y;
        logic [8:0]  next_z;
    } star_result_t;

    star_result_t pending_stars[$];

    // Shadow copy of the configuration registers, updated on every write.
    logic [12:0] cfg_width;
    logic [12:0] cfg_height;
    logic [31:0] cfg_hole1_x;
    logic [31:0] cfg_hole1_y;
    logic [31:0] cfg_hole2_x;
    logic [31:0] cfg_hole2_y;
    logic [3:0]  cfg_shift;
    logic [4:0]  cfg_steps;

    int  error_count;
    int  cycle_count;
    // When quiet_mode is set, neither side inserts idle cycles.
    bit  quiet_mode;
    int  ready_hold;

    starfield_star_update dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .star_x      (star_x),
        .star_y      (star_y),
        .star_z      (star_z),
        .star_color  (star_color),
        .rand_xa     (rand_xa),
        .rand_ya     (rand_ya),
        .rand_xb     (rand_xb),
        .rand_yb     (rand_yb),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .erase_valid (erase_valid),
        .erase_px    (erase_px),
        .erase_py    (erase_py),
        .draw_valid  (draw_valid),
        .draw_px     (draw_px),
        .draw_py     (draw_py),
        .draw_color  (draw_color),
        .next_x      (next_x),
        .next_y      (next_y),
        .next_z      (next_z)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // The whole run is bounded by a cycle counter so a hung handshake still ends it.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Wraps a value to a signed 16-bit coordinate.
    function automatic int wrap16(int v);
        logic signed [15:0] t;
        t = v[15:0];
        return int'(t);
    endfunction

    function automatic bit inside_hole(int px, int py, logic [31:0] hx, logic [31:0] hy);
        logic signed [15:0] left_b, right_b, top_b, bottom_b;
        left_b   = hx[15:0];
        right_b  = hx[31:16];
        top_b    = hy[15:0];
        bottom_b = hy[31:16];
        return px >= left_b && px < right_b && py >= top_b && py < bottom_b;
    endfunction

    // Returns 0 for z <= 0 or off screen, 1 if on screen but hidden by a hole, and
    // 2 if the pixel may be drawn.  Division truncates toward zero, as in hardware.
    function automatic int project_pixel(int x, int y, int z, output int px, output int py);
        int w, h;
        w  = int'(cfg_width);
        h  = int'(cfg_height);
        px = 0;
        py = 0;
        if (z <= 0)
            return 0;
        px = x / z + (w >> 1);
        py = y / z + (h >> 1);
        if (px < 0 || px >= w || py < 0 || py >= h)
            return 0;
        if (inside_hole(px, py, cfg_hole1_x, cfg_hole1_y) ||
            inside_hole(px, py, cfg_hole2_x, cfg_hole2_y))
            return 1;
        return 2;
    endfunction

    // Computes the full update of one star from the current register settings.
    function automatic star_result_t advance_star(
        logic signed [15:0] sx, logic signed [15:0] sy, logic [8:0] sz, logic [4:0] scol,
        logic signed [15:0] xa, logic signed [15:0] ya,
        logic signed [15:0] xb, logic signed [15:0] yb);
        star_result_t r;
        int x, y, z, n, opx, opy, npx, npy, vis;
        bit ev, dv;
        x  = sx;
        y  = sy;
        z  = sz;
        ev = project_pixel(x, y, z, opx, opy) == 2;
        z  = z - DEPTH_STEP;
        if (z <= 0)
        begin
            x = xa;
            y = ya;
            z = MAX_DEPTH;
        end
        else
        begin
            n = int'($signed(cfg_steps));
            // Each step uses the x value it has just produced.
            while (n > 0)
            begin
                x = wrap16(x - (y >>> cfg_shift));
                y = wrap16(y + (x >>> cfg_shift));
                n--;
            end
            while (n < 0)
            begin
                x = wrap16(x + (y >>> cfg_shift));
                y = wrap16(y - (x >>> cfg_shift));
                n++;
            end
        end
        vis = project_pixel(x, y, z, npx, npy);
        dv  = vis == 2;
        if (vis == 0)
        begin
            x = xb;
            y = yb;
            z = MAX_DEPTH;
        end
        r.erase_valid = ev;
        r.erase_px    = ev ? opx[11:0] : 12'd0;
        r.erase_py    = ev ? opy[11:0] : 12'd0;
        r.draw_valid  = dv;
        r.draw_px     = dv ? npx[11:0] : 12'd0;
        r.draw_py     = dv ? npy[11:0] : 12'd0;
        r.draw_color  = dv ? scol : 5'd0;
        r.next_x      = x[15:0];
        r.next_y      = y[15:0];
        r.next_z      = z[8:0];
        return r;
    endfunction

    task automatic report_mismatch(string field, int got, int exp_val);
        if (error_count < PRINT_LIMIT)
            $display("mismatch at cycle %0d on %s: got %0d, expected %0d",
                     cycle_count, field, got, exp_val);
        error_count++;
    endtask

    // Every accepted output transaction is compared with the oldest predicted star.
    always @(posedge clk)
    begin
        star_result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_stars.size() == 0)
                report_mismatch("unexpected output transaction", 1, 0);
            else
            begin
                e = pending_stars.pop_front();
                if (erase_valid !== e.erase_valid)
                    report_mismatch("erase_valid", erase_valid, e.erase_valid);
                if (erase_px !== e.erase_px)
                    report_mismatch("erase_px", erase_px, e.erase_px);
                if (erase_py !== e.erase_py)
                    report_mismatch("erase_py", erase_py, e.erase_py);
                if (draw_valid !== e.draw_valid)
                    report_mismatch("draw_valid", draw_valid, e.draw_valid);
                if (draw_px !== e.draw_px)
                    report_mismatch("draw_px", draw_px, e.draw_px);
                if (draw_py !== e.draw_py)
                    report_mismatch("draw_py", draw_py, e.draw_py);
                if (draw_color !== e.draw_color)
                    report_mismatch("draw_color", draw_color, e.draw_color);
                if (next_x !== e.next_x)
                    report_mismatch("next_x", next_x, e.next_x);
                if (next_y !== e.next_y)
                    report_mismatch("next_y", next_y, e.next_y);
                if (next_z !== e.next_z)
                    report_mismatch("next_z", next_z, e.next_z);
            end
        end
    end

    // The receiver stalls in random bursts, except in quiet mode.
    always @(negedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold <= ready_hold - 1;
            out_ready  <= 1'b0;
        end
        else if (!quiet_mode && $urandom_range(0, 11) == 0)
        begin
            ready_hold <= $urandom_range(0, 17);
            out_ready  <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Writes one register through a setup and an access phase.
    task automatic write_register(reg_idx_t idx, logic [31:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_SCREEN_WIDTH:  cfg_width   = value[12:0];
            REG_SCREEN_HEIGHT: cfg_height  = value[12:0];
            REG_HOLE1_X:       cfg_hole1_x = value;
            REG_HOLE1_Y:       cfg_hole1_y = value;
            REG_HOLE2_X:       cfg_hole2_x = value;
            REG_HOLE2_Y:       cfg_hole2_y = value;
            REG_ROTATE_SHIFT:  cfg_shift   = value[3:0];
            REG_ROTATE_STEPS:  cfg_steps   = value[4:0];
            default: ;
        endcase
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Presents one star transaction and returns once it has been accepted.  The
    // valid line is only lowered when a sender gap is inserted ahead of the item.
    task automatic send_star(logic signed [15:0] sx, logic signed [15:0] sy, logic [8:0] sz,
                             logic [4:0] scol, logic signed [15:0] xa, logic signed [15:0] ya,
                             logic signed [15:0] xb, logic signed [15:0] yb);
        int gap;
        @(negedge clk);
        if (!quiet_mode && $urandom_range(0, 9) == 0)
        begin
            gap = $urandom_range(1, 18);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   = 1'b1;
        star_x     = sx;
        star_y     = sy;
        star_z     = sz;
        star_color = scol;
        rand_xa    = xa;
        rand_ya    = ya;
        rand_xb    = xb;
        rand_yb    = yb;
        do
            @(posedge clk);
        while (!in_ready);
        pending_stars.push_back(advance_star(sx, sy, sz, scol, xa, ya, xb, yb));
    endtask

    // Lowers valid and waits until every predicted star has come back, then lets
    // the pipeline settle before any register is touched.
    task automatic drain_pipeline();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_stars.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 4) @(posedge clk);
    endtask

    // Picks a coordinate that usually lands on screen at depth z, so that the
    // rotation, hole and drawing paths all see traffic; otherwise any value.
    function automatic logic [15:0] pick_coord(int z, logic [12:0] dim);
        int span, v;
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom);
        span = (int'(dim) / 2 + 2) * (z < 1 ? 1 : z);
        if (span > 32767)
            span = 32767;
        v = int'($urandom_range(0, 2 * span)) - span;
        return v[15:0];
    endfunction

    function automatic logic [8:0] pick_depth();
        case ($urandom_range(0, 3))
            0:       return 9'($urandom_range(0, 17));
            1:       return 9'($urandom_range(490, 511));
            default: return 9'($urandom_range(1, 511));
        endcase
    endfunction

    task automatic send_random_stars(int count);
        logic [8:0] z;
        repeat (count)
        begin
            z = pick_depth();
            send_star(pick_coord(z, cfg_width), pick_coord(z, cfg_height), z,
                      5'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom));
        end
    endtask

    // A hole is either fully random or a rectangle placed over the visible area.
    function automatic logic [31:0] pick_hole(logic [12:0] dim);
        int lo, hi;
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        lo = $urandom_range(0, int'(dim));
        hi = lo + $urandom_range(0, int'(dim) / 2 + 1);
        return {hi[15:0], lo[15:0]};
    endfunction

    // The block must come out of reset with its default settings.
    task automatic test_reset_defaults();
        send_star(16'sd0, 16'sd0, 9'd100, 5'd7, 16'sd1, 16'sd2, 16'sd3, 16'sd4);
        send_star(16'sd1000, -16'sd1000, 9'd20, 5'd22, 16'sd5, 16'sd6, 16'sd7, 16'sd8);
        send_random_stars(10);
        drain_pipeline();
    endtask

    // Field extremes and the named special cases: zero depth, passing the viewer,
    // leaving the screen, and stars hidden behind both holes.
    task automatic test_directed_cases();
        write_register(REG_HOLE1_X, {16'sd520, 16'sd500});
        write_register(REG_HOLE1_Y, {16'sd400, 16'sd370});
        write_register(REG_HOLE2_X, {16'sd10, -16'sd5});
        write_register(REG_HOLE2_Y, {16'sd10, -16'sd5});
        send_star(16'sd0, 16'sd0, 9'd0, 5'd31, -16'sd32768, 16'sd32767, 16'sd1, 16'sd1);
        send_star(16'sd0, 16'sd0, 9'd8, 5'd0, 16'sd32767, -16'sd32768, 16'sd0, 16'sd0);
        send_star(16'sd0, 16'sd0, 9'd9, 5'd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_star(16'sd32767, 16'sd32767, 9'd1, 5'd22, 16'sd0, 16'sd0,
                  16'sd32767, 16'sd32767);
        send_star(-16'sd32768, -16'sd32768, 9'd1, 5'd3, 16'sd0, 16'sd0,
                  -16'sd32768, -16'sd32768);
        send_star(16'sd32767, -16'sd32768, 9'd500, 5'd4, 16'sd0, 16'sd0, 16'sd9, 16'sd9);
        send_star(16'sd10, 16'sd10, 9'd511, 5'd5, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_star(16'sd1000, 16'sd500, 9'd100, 5'd6, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_star(-16'sd1000, -16'sd500, 9'd100, 5'd8, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_star(16'sd512, 16'sd384, 9'd1, 5'd9, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_star(-16'sd512, -16'sd384, 9'd1, 5'd10, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_star(16'sd511, 16'sd383, 9'd1, 5'd11, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        drain_pipeline();
        // Clockwise rotation with no shift and a 4096 by 4096 screen.
        write_register(REG_ROTATE_STEPS, 5'b11000);
        write_register(REG_ROTATE_SHIFT, 4'd0);
        write_register(REG_SCREEN_WIDTH, 32'd4096);
        write_register(REG_SCREEN_HEIGHT, 32'd4096);
        send_star(16'sd300, -16'sd200, 9'd50, 5'd12, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_star(-16'sd32768, 16'sd32767, 9'd400, 5'd13, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_star(16'sd1, -16'sd1, 9'd20, 5'd14, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        drain_pipeline();
    endtask

    // Several register settings, fixed ones with the extremes and random ones, each
    // followed by a batch of random stars.
    task automatic test_random_settings();
        logic [31:0] w, h, shift, steps;
        for (int phase = 0; phase < 7; phase++)
        begin
            case (phase)
                0: begin w = 2;    h = 2;    shift = 0;  steps = 5'b11000; end
                1: begin w = 4096; h = 4096; shift = 15; steps = 5'd8;     end
                2: begin w = 8191; h = 8191; shift = 1;  steps = 5'b10000; end
                3: begin w = 3;    h = 4095; shift = 4;  steps = 5'd15;    end
                4: begin w = 1024; h = 768;  shift = 6;  steps = 5'd0;     end
                default:
                begin
                    w     = $urandom_range(2, 8191);
                    h     = $urandom_range(2, 8191);
                    shift = $urandom_range(0, 15);
                    steps = $urandom_range(0, 31);
                end
            endcase
            write_register(REG_SCREEN_WIDTH, w);
            write_register(REG_SCREEN_HEIGHT, h);
            write_register(REG_ROTATE_SHIFT, shift);
            write_register(REG_ROTATE_STEPS, steps);
            write_register(REG_HOLE1_X, pick_hole(cfg_width));
            write_register(REG_HOLE1_Y, pick_hole(cfg_height));
            write_register(REG_HOLE2_X, pick_hole(cfg_width));
            write_register(REG_HOLE2_Y, pick_hole(cfg_height));
            send_random_stars(200);
            drain_pipeline();
        end
    endtask

    // The closing stretch runs back to back with no stalls on either side.
    task automatic test_full_rate();
        write_register(REG_SCREEN_WIDTH, 32'd1024);
        write_register(REG_SCREEN_HEIGHT, 32'd768);
        write_register(REG_ROTATE_SHIFT, 32'd6);
        write_register(REG_ROTATE_STEPS, 32'd3);
        quiet_mode = 1'b1;
        @(negedge clk);
        while (ready_hold != 0)
            @(negedge clk);
        send_random_stars(150);
        drain_pipeline();
    endtask

    initial
    begin
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_valid    = 1'b0;
        star_x      = '0;
        star_y      = '0;
        star_z      = '0;
        star_color  = '0;
        rand_xa     = '0;
        rand_ya     = '0;
        rand_xb     = '0;
        rand_yb     = '0;
        out_ready   = 1'b0;
        ready_hold  = 0;
        quiet_mode  = 1'b0;
        error_count = 0;
        cycle_count = 0;
        cfg_width   = 13'd1024;
        cfg_height  = 13'd768;
        cfg_hole1_x = '0;
        cfg_hole1_y = '0;
        cfg_hole2_x = '0;
        cfg_hole2_y = '0;
        cfg_shift   = 4'd6;
        cfg_steps   = 5'd3;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        test_reset_defaults();
        test_directed_cases();
        test_random_settings();
        test_full_rate();

        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
